// ----- rtl/lphs_pkg.sv -----
// shared types and constants for the linear probe hash set
package lphs_pkg;

   localparam int KEY_W        = 64;
   localparam int STATUS_W     = 2;
   localparam int SLOT_INDEX_W = 10;
   localparam int COUNT_W      = 11;
   localparam int LIMIT_W      = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 11;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_EXISTS   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_LIMIT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRICT_LIMIT = 1'd1;

   localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = 11'd768;

   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic [COUNT_W-1:0]      entry_count;
   } rsp_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] entry_limit;
      logic               strict_limit;
   } cfg_type;

   typedef struct packed {
      logic             done;
      logic [KEY_W-1:0] value;
   } hash_rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_CHECK
   } ctrl_state_type;

endpackage

// ----- rtl/lphs_ram.sv -----
// generic simple dual-port ram with registered read
module lphs_ram #(
   parameter int WIDTH = 65,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/lphs_hash.sv -----
// iterative 64-bit fnv-1a hash, one key byte per cycle
module lphs_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lphs_pkg::KEY_W-1:0] key,
   output lphs_pkg::hash_rsp_type     hash_rsp
);
   import lphs_pkg::*;

   localparam logic [KEY_W-1:0] FNV_BASIS    = 64'hCBF29CE484222325;
   localparam logic [KEY_W-1:0] FNV_PRIME_LO = 64'h00000000000001B3;
   localparam int               FNV_PRIME_SH = 40;

   // prime is 2^40 + 0x1b3
   function automatic logic [KEY_W-1:0] fnv_step(input logic [KEY_W-1:0] h,
                                                 input logic [7:0] b);
      logic [KEY_W-1:0] x;
      x = h ^ {{(KEY_W-8){1'b0}}, b};
      return (x << FNV_PRIME_SH) + (x * FNV_PRIME_LO);
   endfunction

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [2:0]       step_ff, step_in;
   logic [KEY_W-1:0] shift_ff, shift_in;
   logic [KEY_W-1:0] h_ff, h_in;

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      h_in     = h_ff;
      if (start) begin
         run_in   = 1'b1;
         step_in  = '0;
         shift_in = key;
         h_in     = FNV_BASIS;
      end else if (run_ff) begin
         h_in     = fnv_step(h_ff, shift_ff[7:0]);
         shift_in = shift_ff >> 8;
         step_in  = step_ff + 3'd1;
         if (&step_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      h_ff     <= h_in;
   end

   assign hash_rsp.done  = done_ff;
   assign hash_rsp.value = h_ff;

endmodule

// ----- rtl/lphs_ctrl.sv -----
// probe sequencer: table clear, hash wait, slot walk, insert and response
module lphs_ctrl #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  lphs_pkg::req_type                 req_data,
   input  lphs_pkg::cfg_type                 cfg,
   output logic                              busy,
   output logic                              hash_start,
   input  lphs_pkg::hash_rsp_type            hash_rsp,
   output logic                              ram_we,
   output logic [$clog2(TABLE_SLOTS)-1:0]    ram_waddr,
   output logic [lphs_pkg::KEY_W:0]          ram_wdata,
   output logic [$clog2(TABLE_SLOTS)-1:0]    ram_raddr,
   input  logic [lphs_pkg::KEY_W:0]          ram_rdata,
   output logic                              rsp_valid,
   output lphs_pkg::rsp_type                 rsp_data
);
   import lphs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] home_ff, home_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             slot_used;
   logic             key_match;
   logic             probe_done;
   logic             found;
   logic             full;
   logic [IDX_W-1:0] slot;

   assign slot_used  = ram_rdata[KEY_W];
   assign key_match  = (ram_rdata[KEY_W-1:0] == key_ff);
   assign probe_done = !slot_used || key_match || (&cnt_ff);
   assign found      = slot_used && key_match;
   assign slot       = (slot_used && !key_match) ? home_ff : idx_ff;
   assign full       = slot_used
                    || (CMP_W'(count_ff) >= CMP_W'(TABLE_SLOTS))
                    || (cfg.strict_limit && (CMP_W'(count_ff) >= CMP_W'(cfg.entry_limit)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_rsp.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (probe_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      busy         = 1'b1;
      hash_start   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = {1'b1, key_ff};
      ram_raddr    = IDX_W'(idx_ff + 1'b1);
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      home_in      = home_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = IDX_W'(clr_ff + 1'b1);
         end
         ST_IDLE: begin
            busy       = 1'b0;
            hash_start = start;
            if (start) begin
               op_in  = req_data.opcode;
               key_in = req_data.key;
            end
         end
         ST_HASH: begin
            if (hash_rsp.done) begin
               ram_raddr = hash_rsp.value[IDX_W-1:0];
               idx_in    = hash_rsp.value[IDX_W-1:0];
               home_in   = hash_rsp.value[IDX_W-1:0];
               cnt_in    = '0;
            end
         end
         ST_CHECK: begin
            if (!probe_done) begin
               idx_in = IDX_W'(idx_ff + 1'b1);
               cnt_in = IDX_W'(cnt_ff + 1'b1);
            end else begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_QUERY) begin
                  rsp_in.status = found ? STATUS_PRESENT : STATUS_ABSENT;
               end else if (found) begin
                  rsp_in.status = STATUS_EXISTS;
               end else if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status = STATUS_INSERTED;
                  ram_we        = 1'b1;
                  ram_waddr     = idx_ff;
                  count_in      = CNT_W'(count_ff + 1'b1);
               end
               rsp_in.slot_index  = SLOT_INDEX_W'(slot);
               rsp_in.entry_count = COUNT_W'(count_in);
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff  <= idx_in;
      home_ff <= home_in;
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/linear_probe_hash_set_top.sv -----
// top level of the linear probe hash set: csr registers, hash, sequencer, slot ram
//
//   channel   ports                               handshake
//   request   start, busy, req_data               taken when start && !busy
//   response  rsp_valid, rsp_data                 one-cycle strobe, no backpressure
//   csr       csr_we, csr_index, csr_wdata        written when csr_we
//
// after reset the slot ram is cleared, one slot a cycle, and busy stays high until the clear is done
// a request is taken, hashed, then probed slot by slot until its response is registered
// the fnv hash takes the key one byte at a time; each probe is one read of the slot ram
// busy drops in the response cycle, so the next request can be taken there
// the receiver cannot stall; each response is shown for exactly one cycle
module linear_probe_hash_set_top #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lphs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output lphs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [lphs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lphs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lphs_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   cfg_type          cfg_ff, cfg_in;
   logic             hash_start;
   hash_rsp_type     hash_rsp;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [KEY_W:0]   ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [KEY_W:0]   ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENTRY_LIMIT: cfg_in.entry_limit = csr_wdata[LIMIT_W-1:0];
            CSR_STRICT_LIMIT: cfg_in.strict_limit = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_limit  <= ENTRY_LIMIT_RESET;
         cfg_ff.strict_limit <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lphs_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hash_start),
      .key      (req_data.key),
      .hash_rsp (hash_rsp)
   );

   lphs_ctrl #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .busy       (busy),
      .hash_start (hash_start),
      .hash_rsp   (hash_rsp),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   lphs_ram #(
      .WIDTH (KEY_W + 1),
      .DEPTH (TABLE_SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request was taken");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while the sequencer is busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != 2'd3))
      else $error("response status outside the defined codes");
`endif

endmodule

// ----- dv/lphs_checker.sv -----
`timescale 1ns / 1ps
// checker: predicts the hash set responses from the requests and compares them with the block
module lphs_checker #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  lphs_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  lphs_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [lphs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lphs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               error_count
);
   import lphs_pkg::*;

   localparam logic [KEY_W-1:0] FNV_OFFSET = 64'd14695981039346656037;
   localparam logic [KEY_W-1:0] FNV_PRIME  = 64'd1099511628211;
   localparam int               REPORT_CAP = 100;

   logic [KEY_W-1:0]   stored_keys [TABLE_SLOTS];
   logic               slot_taken [TABLE_SLOTS];
   int unsigned        key_total;
   logic [LIMIT_W-1:0] limit_value;
   logic               limit_on;
   rsp_type            due_rsp [$];
   int                 awaited = 0;
   int                 mismatches = 0;

   assign error_count = mismatches + awaited;

   function automatic int unsigned home_slot_of(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] h;
      h = FNV_OFFSET;
      for (int b = 0; b < 8; b++) begin
         h = (h ^ {56'd0, key[8*b +: 8]}) * FNV_PRIME;
      end
      return int'(h % 64'(TABLE_SLOTS));
   endfunction

   function automatic rsp_type lookup_or_insert(req_type r);
      int unsigned home;
      int unsigned idx;
      int unsigned slot;
      int          n;
      bit          found;
      bit          met_empty;
      bit          refused;
      rsp_type     res;
      home      = home_slot_of(r.key);
      idx       = home;
      slot      = home;
      found     = 1'b0;
      met_empty = 1'b0;
      n         = 0;
      // one sweep at most, wrapping at the end of the table
      while (n < TABLE_SLOTS && !found && !met_empty) begin
         if (!slot_taken[idx]) begin
            slot      = idx;
            met_empty = 1'b1;
         end else if (stored_keys[idx] == r.key) begin
            slot  = idx;
            found = 1'b1;
         end else begin
            idx = (idx + 1) % TABLE_SLOTS;
         end
         n++;
      end
      if (r.opcode == OP_QUERY) begin
         res.status = found ? STATUS_PRESENT : STATUS_ABSENT;
      end else if (found) begin
         res.status = STATUS_EXISTS;
      end else begin
         refused = !met_empty || key_total >= TABLE_SLOTS ||
                   (limit_on && key_total >= limit_value);
         if (refused) begin
            res.status = STATUS_FULL;
         end else begin
            stored_keys[slot] = r.key;
            slot_taken[slot]  = 1'b1;
            key_total++;
            res.status = STATUS_INSERTED;
         end
      end
      res.slot_index  = SLOT_INDEX_W'(slot);
      res.entry_count = COUNT_W'(key_total);
      return res;
   endfunction

   task automatic note_mismatch(string field, int want, int got);
      if (mismatches < REPORT_CAP) begin
         $error("%s expected %0d got %0d", field, want, got);
      end
      mismatches++;
   endtask

   task automatic compare_response(rsp_type got);
      rsp_type want;
      if (due_rsp.size() == 0) begin
         if (mismatches < REPORT_CAP) begin
            $error("response with no request outstanding: status %0d slot_index %0d count %0d",
                   got.status, got.slot_index, got.entry_count);
         end
         mismatches++;
      end else begin
         want = due_rsp.pop_front();
         awaited--;
         if (got.status !== want.status) begin
            note_mismatch("status", want.status, got.status);
         end
         if (got.slot_index !== want.slot_index) begin
            note_mismatch("slot_index", want.slot_index, got.slot_index);
         end
         if (got.entry_count !== want.entry_count) begin
            note_mismatch("entry_count", want.entry_count, got.entry_count);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_taken[i] = 1'b0;
         end
         key_total   = 0;
         limit_value = ENTRY_LIMIT_RESET;
         limit_on    = 1'b0;
         due_rsp.delete();
         awaited = 0;
      end else begin
         if (rsp_valid) begin
            compare_response(rsp_data);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ENTRY_LIMIT: begin
                  limit_value = csr_wdata[LIMIT_W-1:0];
               end
               CSR_STRICT_LIMIT: begin
                  limit_on = csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (start && !busy) begin
            due_rsp.push_back(lookup_or_insert(req_data));
            awaited++;
         end
      end
   end

endmodule

// ----- dv/linear_probe_hash_set_top_tb.sv -----
`timescale 1ns / 1ps
// testbench top: drives requests and csr writes into the hash set and reports the verdict
module linear_probe_hash_set_top_tb;
   import lphs_pkg::*;

   localparam int TABLE_SLOTS = 1024;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_valid;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;

   int unsigned        sent_total = 0;
   int unsigned        rsp_total = 0;
   int unsigned        burst_left = 0;
   logic [COUNT_W-1:0] last_count = '0;
   logic [KEY_W-1:0]   key_pool [$];

   linear_probe_hash_set_top #(.TABLE_SLOTS(TABLE_SLOTS)) dut (.*);

   lphs_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (rsp_valid && !reset) begin
         rsp_total++;
         last_count <= rsp_data.entry_count;
      end
   end

   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (rsp_total != sent_total || busy);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      wait_idle();
      csr_index <= idx;
      csr_wdata <= data;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send(logic op, logic [KEY_W-1:0] key);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data <= '{opcode: op, key: key};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sent_total++;
      @(negedge clock);
   endtask

   task automatic random_items(int count, int insert_pct, int reuse_pct);
      logic             op;
      logic [KEY_W-1:0] k;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(49) == 0) begin
            wait_idle();
         end
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_QUERY;
         if (key_pool.size() > 0 && $urandom_range(99) < reuse_pct) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
         end else begin
            k = {$urandom, $urandom};
            if ($urandom_range(9) == 0) begin
               k = k >> $urandom_range(63);
            end
            if (op == OP_INSERT) begin
               key_pool.push_back(k);
            end
         end
         send(op, k);
      end
   endtask

   initial begin
      logic [KEY_W-1:0] k;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limit of zero in strict mode refuses the very first insert
      write_csr(CSR_ENTRY_LIMIT, 11'd0);
      write_csr(CSR_STRICT_LIMIT, 11'h001);
      send(OP_INSERT, 64'd0);
      send(OP_QUERY, 64'd0);
      // upper bits of the strict flag are dropped
      write_csr(CSR_STRICT_LIMIT, 11'h7FE);
      send(OP_INSERT, 64'd0);
      send(OP_INSERT, 64'd0);
      send(OP_QUERY, 64'd0);
      send(OP_INSERT, '1);
      send(OP_QUERY, '1);
      send(OP_QUERY, 64'h8000_0000_0000_0001);
      send(OP_INSERT, 64'h0123_4567_89AB_CDEF);
      // limit above the slot count
      write_csr(CSR_ENTRY_LIMIT, 11'h7FF);
      write_csr(CSR_STRICT_LIMIT, 11'h7FF);
      send(OP_INSERT, 64'h5555_5555_5555_5555);
      send(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      write_csr(CSR_ENTRY_LIMIT, 11'd1);
      send(OP_INSERT, 64'hFEDC_BA98_7654_3210);
      send(OP_INSERT, 64'd0);
      send(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
      key_pool.push_back(64'd0);
      key_pool.push_back('1);
      key_pool.push_back(64'h0123_4567_89AB_CDEF);
      key_pool.push_back(64'h5555_5555_5555_5555);
      key_pool.push_back(64'hAAAA_AAAA_AAAA_AAAA);

      write_csr(CSR_ENTRY_LIMIT, ENTRY_LIMIT_RESET);
      write_csr(CSR_STRICT_LIMIT, 11'd0);
      random_items(60, 60, 30);
      write_csr(CSR_ENTRY_LIMIT, 11'd40);
      write_csr(CSR_STRICT_LIMIT, 11'd1);
      random_items(40, 60, 40);
      write_csr(CSR_ENTRY_LIMIT, 11'd1);
      random_items(20, 50, 50);
      write_csr(CSR_ENTRY_LIMIT, 11'h7FF);
      random_items(60, 70, 30);
      write_csr(CSR_ENTRY_LIMIT, 11'd300);
      random_items(40, 70, 30);
      write_csr(CSR_ENTRY_LIMIT, 11'd1024);
      write_csr(CSR_STRICT_LIMIT, 11'd0);
      random_items(40, 60, 30);

      // fill every slot, then work on the full table
      while (last_count < TABLE_SLOTS) begin
         k = {$urandom, $urandom};
         key_pool.push_back(k);
         send(OP_INSERT, k);
      end
      random_items(20, 50, 50);
      write_csr(CSR_ENTRY_LIMIT, 11'd0);
      write_csr(CSR_STRICT_LIMIT, 11'd1);
      random_items(10, 70, 70);

      wait_idle();
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
